### rtl/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants for the signed integer divider.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int DEFAULT_WIDTH = 32;
    localparam int FIELD_W       = 32;

    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_status;

endpackage

### rtl/sid_ctrl.sv
// ----------------------------------------------------------------------------
// sid_ctrl
// Sequencer for the divider: load, one step per quotient bit, sign fix-up.
// ----------------------------------------------------------------------------
module sid_ctrl
    import sid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_FIXUP
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    n_state = S_FIXUP;
                end
            end
            S_FIXUP: begin
                o_cmd.fix = 1'b1;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

### rtl/sid_datapath.sv
// ----------------------------------------------------------------------------
// sid_datapath
// Magnitude capture, restoring shift-subtract divider and sign restore.
// ----------------------------------------------------------------------------
module sid_datapath
    import sid_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic signed [FIELD_W-1:0] i_dividend,
    input  logic signed [FIELD_W-1:0] i_divisor,
    output t_dp_status                o_status,
    output logic signed [FIELD_W-1:0] o_quotient,
    output logic signed [FIELD_W-1:0] o_remainder,
    output logic                      o_div_by_zero
);

    localparam int CW = $clog2(WIDTH);

    logic [63:0]      ext_a, ext_b, ext_q, ext_r;
    logic [WIDTH-1:0] a, b, mag_a, mag_b, q_fix, r_fix;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH+1:0] diff;

    logic [WIDTH-1:0] r_quo, r_rem, r_dvs;
    logic [CW-1:0]    r_count;
    logic             r_neg_q, r_neg_r, r_zero;
    logic [FIELD_W-1:0] r_quotient, r_remainder;
    logic             r_div_by_zero;

    assign ext_a = 64'(i_dividend);
    assign ext_b = 64'(i_divisor);
    assign a     = ext_a[WIDTH-1:0];
    assign b     = ext_b[WIDTH-1:0];
    assign mag_a = a[WIDTH-1] ? (~a + WIDTH'(1)) : a;
    assign mag_b = b[WIDTH-1] ? (~b + WIDTH'(1)) : b;

    assign rem_shift = {r_rem, r_quo[WIDTH-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, r_dvs};

    assign q_fix = r_zero ? '0 : (r_neg_q ? (~r_quo + WIDTH'(1)) : r_quo);
    assign r_fix = r_zero ? '0 : (r_neg_r ? (~r_rem + WIDTH'(1)) : r_rem);
    assign ext_q = 64'(signed'(q_fix));
    assign ext_r = 64'(signed'(r_fix));

    assign o_status.last = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= CW'(WIDTH - 1);
        end else if (i_cmd.step) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo   <= mag_a;
            r_rem   <= '0;
            r_dvs   <= mag_b;
            r_neg_q <= a[WIDTH-1] ^ b[WIDTH-1];
            r_neg_r <= a[WIDTH-1];
            r_zero  <= (b == '0);
        end else if (i_cmd.step) begin
            if (!diff[WIDTH+1]) begin
                r_rem <= diff[WIDTH-1:0];
            end else begin
                r_rem <= rem_shift[WIDTH-1:0];
            end
            r_quo <= {r_quo[WIDTH-2:0], ~diff[WIDTH+1]};
        end
        if (i_cmd.fix) begin
            r_quotient    <= ext_q[FIELD_W-1:0];
            r_remainder   <= ext_r[FIELD_W-1:0];
            r_div_by_zero <= r_zero;
        end
    end

    assign o_quotient    = r_quotient;
    assign o_remainder   = r_remainder;
    assign o_div_by_zero = r_div_by_zero;

endmodule

### rtl/signed_integer_divider.sv
// ----------------------------------------------------------------------------
// signed_integer_divider
// Truncating signed division with remainder and divide-by-zero flag.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The result appears
// on o_quotient, o_remainder and o_div_by_zero after a load, one step per
// quotient bit in the shift-subtract loop and a sign fix-up, and is shown
// for one cycle with o_done high; the receiver cannot stall, so capture it
// then. busy drops in the cycle o_done is shown, so a new item may start
// from that cycle on, but not while the last one is still in work.
// The quotient truncates toward zero, the remainder takes the dividend's
// sign, a zero divisor gives zeros with the flag set, and the most negative
// dividend over minus one wraps to the most negative value.
// ----------------------------------------------------------------------------
module signed_integer_divider
    import sid_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [FIELD_W-1:0] i_dividend,
    input  logic signed [FIELD_W-1:0] i_divisor,
    output logic                      o_done,
    output logic signed [FIELD_W-1:0] o_quotient,
    output logic signed [FIELD_W-1:0] o_remainder,
    output logic                      o_div_by_zero
);

    t_dp_cmd    cmd;
    t_dp_status status;

    sid_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    sid_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_dividend    (i_dividend),
        .i_divisor     (i_divisor),
        .o_status      (status),
        .o_quotient    (o_quotient),
        .o_remainder   (o_remainder),
        .o_div_by_zero (o_div_by_zero)
    );

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe without preceding work");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_div_by_zero |-> o_quotient == '0 && o_remainder == '0)
        else $error("divide by zero result not cleared");

endmodule
